// File: sv/pts_pkg.sv
package pts_pkg;

    localparam int FRAC_BITS = 8;

    localparam int ID_W     = 8;
    localparam int CPU_W    = 31;
    localparam int NICE_W   = 6;
    localparam int PRIO_W   = 8;
    localparam int USAGE_W  = CPU_W - FRAC_BITS - 2;
    localparam int CALC_W   = USAGE_W + 10;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = CFG_IDX_W'(1);

    localparam logic [PRIO_W-1:0] CEILING_RESET = PRIO_W'(127);
    localparam logic [PRIO_W-1:0] FLOOR_RESET   = PRIO_W'(0);

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic            idle;
    } t_decision;

endpackage

// File: sv/pts_prio.sv
module pts_prio
    import pts_pkg::*;
(
    input  logic [CPU_W-1:0]         i_cpu_usage,
    input  logic signed [NICE_W-1:0] i_nice_value,
    input  logic [PRIO_W-1:0]        i_ceiling,
    input  logic [PRIO_W-1:0]        i_floor,
    output logic [PRIO_W-1:0]        o_priority
);

    logic [USAGE_W-1:0]       usage;
    logic signed [CALC_W-1:0] raw;
    logic signed [CALC_W-1:0] lo_clamped;
    logic signed [CALC_W-1:0] ceil_s;
    logic signed [CALC_W-1:0] floor_s;

    always_comb begin
        usage   = i_cpu_usage[CPU_W-1:FRAC_BITS+2];
        ceil_s  = $signed({{(CALC_W-PRIO_W){1'b0}}, i_ceiling});
        floor_s = $signed({{(CALC_W-PRIO_W){1'b0}}, i_floor});
        raw     = ceil_s
                - $signed({{(CALC_W-USAGE_W){1'b0}}, usage})
                - $signed({{(CALC_W-NICE_W-1){i_nice_value[NICE_W-1]}}, i_nice_value, 1'b0});
        // lower clamp first, upper clamp wins
        lo_clamped = (raw < floor_s) ? floor_s : raw;
        if (lo_clamped > ceil_s) begin
            o_priority = i_ceiling;
        end else begin
            o_priority = lo_clamped[PRIO_W-1:0];
        end
    end

endmodule

// File: sv/pts_select.sv
module pts_select
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [ID_W-1:0]   i_task_id,
    input  logic              i_task_ready,
    input  logic              i_last_task,
    input  logic [PRIO_W-1:0] i_priority,
    output t_decision         o_decision
);

    logic              r_have_best;
    logic [PRIO_W-1:0] r_best_prio;
    logic [ID_W-1:0]   r_best_id;
    logic              n_have_best;
    logic [PRIO_W-1:0] n_best_prio;
    logic [ID_W-1:0]   n_best_id;
    logic              take;

    always_comb begin
        take = (i_task_id != '0) && i_task_ready
            && (!r_have_best || (i_priority > r_best_prio));
        n_have_best = r_have_best;
        n_best_prio = r_best_prio;
        n_best_id   = r_best_id;
        if (take) begin
            n_have_best = 1'b1;
            n_best_prio = i_priority;
            n_best_id   = i_task_id;
        end
        o_decision.valid = i_last_task;
        o_decision.id    = (i_last_task && n_have_best) ? n_best_id : '0;
        o_decision.idle  = i_last_task && !n_have_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_best_prio <= '0;
            r_best_id   <= '0;
        end else if (i_advance) begin
            if (i_last_task) begin
                r_have_best <= 1'b0;
                r_best_prio <= '0;
                r_best_id   <= '0;
            end else begin
                r_have_best <= n_have_best;
                r_best_prio <= n_best_prio;
                r_best_id   <= n_best_id;
            end
        end
    end

endmodule

// File: sv/priority_task_selector.sv
// Priority task selector.
// Input channel: one task record per transfer (i_task_id, i_task_ready,
// i_cpu_usage, i_nice_value, i_last_task), taken when i_in_valid is high
// and o_in_stall is low. Output channel: one result per record
// (o_task_priority, o_decision_valid, o_chosen_id, o_idle_chosen), taken
// when o_out_valid is high and i_out_stall is low. The record marked last
// carries the decision for the list and starts a new list.
// A record goes to the input register, then to the result register.
// Throughput: one record per cycle while i_out_stall is low; the priority
// formula, clamp and best-task compare sit in one combinational stage.
// Configuration: index 0 sets the ceiling, index 1 the floor; o_cfg_ready is
// always high. Write only while the block is empty.
// Reset (i_rst_n low, synchronous): both stages empty, running best cleared,
// ceiling 127, floor 0.
// Stall: when i_out_stall holds a waiting result, the input register still
// takes one record; o_in_stall rises only when both stages are full.
module priority_task_selector
    import pts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [PRIO_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [ID_W-1:0]          i_task_id,
    input  logic                     i_task_ready,
    input  logic [CPU_W-1:0]         i_cpu_usage,
    input  logic signed [NICE_W-1:0] i_nice_value,
    input  logic                     i_last_task,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PRIO_W-1:0]        o_task_priority,
    output logic                     o_decision_valid,
    output logic [ID_W-1:0]          o_chosen_id,
    output logic                     o_idle_chosen
);

    logic [PRIO_W-1:0]        r_ceiling;
    logic [PRIO_W-1:0]        r_floor;
    logic                     r_s1_valid;
    logic [ID_W-1:0]          r_s1_id;
    logic                     r_s1_ready;
    logic [CPU_W-1:0]         r_s1_cpu;
    logic signed [NICE_W-1:0] r_s1_nice;
    logic                     r_s1_last;
    logic                     r_out_valid;
    logic [PRIO_W-1:0]        r_out_prio;
    t_decision                r_out_dec;
    logic                     out_adv;
    logic                     s1_adv;
    logic                     s1_fire;
    logic [PRIO_W-1:0]        prio;
    t_decision                dec;

    assign o_cfg_ready = 1'b1;
    assign out_adv     = !r_out_valid || !i_out_stall;
    assign s1_adv      = !r_s1_valid || out_adv;
    assign s1_fire     = r_s1_valid && out_adv;
    assign o_in_stall  = !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= CEILING_RESET;
            r_floor   <= FLOOR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CEILING: r_ceiling <= i_cfg_data;
                REG_FLOOR:   r_floor   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_in_valid) begin
            r_s1_id    <= i_task_id;
            r_s1_ready <= i_task_ready;
            r_s1_cpu   <= i_cpu_usage;
            r_s1_nice  <= i_nice_value;
            r_s1_last  <= i_last_task;
        end
    end

    pts_prio u_prio (
        .i_cpu_usage  (r_s1_cpu),
        .i_nice_value (r_s1_nice),
        .i_ceiling    (r_ceiling),
        .i_floor      (r_floor),
        .o_priority   (prio)
    );

    pts_select u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (s1_fire),
        .i_task_id    (r_s1_id),
        .i_task_ready (r_s1_ready),
        .i_last_task  (r_s1_last),
        .i_priority   (prio),
        .o_decision   (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_prio <= prio;
            r_out_dec  <= dec;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_task_priority  = r_out_prio;
    assign o_decision_valid = r_out_dec.valid;
    assign o_chosen_id      = r_out_dec.id;
    assign o_idle_chosen    = r_out_dec.idle;

    a_idle_only_on_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dec.idle) |-> r_out_dec.valid)
        else $error("idle flag on a result without a decision");

    a_chosen_not_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dec.valid && !r_out_dec.idle) |-> (r_out_dec.id != '0))
        else $error("task 0 reported as chosen");

    a_quiet_without_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_dec.valid) |-> (r_out_dec.id == '0 && !r_out_dec.idle))
        else $error("decision fields set on a non-final result");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule
